@@ rtl/sha1_pkg.sv @@
// Package for the SHA-1 message hasher: beat payload types, control structs,
// round constants, initial hash values and the round function.
// No dependencies; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int NUM_WORDS = 16;
    localparam int LEN_W   = 61;
    localparam int CNT_W   = 6;
    localparam int RND_W   = 7;

    localparam logic [CNT_W-1:0]  BLOCK_LAST = 6'd63;
    localparam logic [CNT_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [RND_W-1:0]  ROUND_LAST = 7'd79;
    localparam logic [RND_W-1:0]  STAGE1_START = 7'd20;
    localparam logic [RND_W-1:0]  STAGE2_START = 7'd40;
    localparam logic [RND_W-1:0]  STAGE3_START = 7'd60;
    localparam logic [BYTE_W-1:0] PAD_MARKER = 8'h80;
    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};

    localparam logic [1:0] STG_CHOOSE = 2'd0;
    localparam logic [1:0] STG_PARITY = 2'd1;
    localparam logic [1:0] STG_MAJ    = 2'd2;
    localparam logic [1:0] STG_PARITY2 = 2'd3;

    localparam logic [WORD_W-1:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [WORD_W-1:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_t;

    typedef struct packed {
        logic byte_shift;
        logic word_shift;
    } sched_ctrl_t;

    typedef struct packed {
        logic       load_vars;
        logic       step;
        logic       fold;
        logic       init_chain;
        logic [1:0] stage;
    } round_ctrl_t;

    function automatic logic [WORD_W-1:0] round_f(
        input logic [1:0]        stage,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] f;
        case (stage)
            STG_CHOOSE: f = (b & c) | (~b & d);
            STG_MAJ:    f = (b & c) | (b & d) | (c & d);
            default:    f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha1_sched_cell.sv @@
// One word cell of the SHA-1 message schedule shift chain.
// Shifts a byte or a whole word in from its right-hand neighbor; uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1_sched_cell (
    input  wire logic                  clk,
    input  wire sha1_pkg::sched_ctrl_t ctrl,
    input  wire logic [31:0]           next_word,
    output logic [31:0]                word
);
    import sha1_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.word_shift)
        begin
            word_next = next_word;
        end
        else if (ctrl.byte_shift)
        begin
            word_next = {word_reg[WORD_W-BYTE_W-1:0], next_word[WORD_W-1:WORD_W-BYTE_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

@@ rtl/sha1_round.sv @@
// SHA-1 round datapath: working variables a..e, the chaining value and the
// per-round update and final fold. Uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1_round (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha1_pkg::round_ctrl_t ctrl,
    input  wire logic [31:0]           w,
    output sha1_pkg::out_t             chain
);
    import sha1_pkg::*;

    logic [WORD_W-1:0] vars_reg  [5];
    logic [WORD_W-1:0] vars_next [5];
    logic [WORD_W-1:0] chain_reg  [5];
    logic [WORD_W-1:0] chain_next [5];
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] tmp;

    assign f_val = round_f(ctrl.stage, vars_reg[1], vars_reg[2], vars_reg[3]);
    assign tmp   = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val + vars_reg[4] + w
                   + ROUND_K[ctrl.stage];

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            vars_next[i]  = vars_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (ctrl.load_vars)
        begin
            for (int i = 0; i < 5; i++)
            begin
                vars_next[i] = chain_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            vars_next[0] = tmp;
            vars_next[1] = vars_reg[0];
            vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3];
        end
        if (ctrl.init_chain)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = H_INIT[i];
            end
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                vars_reg[i]  <= '0;
                chain_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                vars_reg[i]  <= vars_next[i];
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    assign chain.digest_word0 = chain_reg[0];
    assign chain.digest_word1 = chain_reg[1];
    assign chain.digest_word2 = chain_reg[2];
    assign chain.digest_word3 = chain_reg[3];
    assign chain.digest_word4 = chain_reg[4];

endmodule

`default_nettype wire

@@ rtl/sha1_message_hasher.sv @@
// SHA-1 message hasher top level: input control, padding, length count,
// schedule cell chain and digest output register. Uses sha1_pkg,
// sha1_sched_cell and sha1_round.
//
// A message enters one byte per beat; a beat with end_of_message set (with or
// without a byte) closes it, and one beat of five digest words follows. A byte
// beat is taken whenever msg_ready is high; every 64th byte starts a block
// compression (80 rounds plus the chaining add) during which msg_ready is low.
// Closing a message feeds 9 to 72 padding bytes, runs one or two compressions
// and loads the digest register; the next message may start while the digest
// beat still waits on digest_ready.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_hasher (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           msg_valid,
    output logic                msg_ready,
    input  wire sha1_pkg::in_t  msg,
    output logic                digest_valid,
    input  wire logic           digest_ready,
    output sha1_pkg::out_t      digest
);
    import sha1_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic              end_pend_reg, end_pend_next;
    logic              marker_reg, marker_next;
    logic              in_len_reg, in_len_next;
    logic              last_blk_reg, last_blk_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    sched_ctrl_t       sched_ctrl;
    round_ctrl_t       round_ctrl;
    logic [BYTE_W-1:0] feed_byte;
    logic [WORD_W-1:0] sched_q [NUM_WORDS];
    logic [WORD_W-1:0] w_mix;
    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] tail_word;
    logic [63:0]       bit_len;
    logic [2:0]        len_idx;
    logic [BYTE_W-1:0] len_byte;
    out_t              chain;

    assign bit_len  = {len_reg, 3'b000};
    assign len_idx  = ~cnt_reg[2:0];
    assign len_byte = bit_len[{len_idx, 3'b000} +: BYTE_W];

    assign w_mix     = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    assign w_new     = {w_mix[30:0], w_mix[31]};
    assign tail_word = sched_ctrl.byte_shift ? {feed_byte, {(WORD_W-BYTE_W){1'b0}}} : w_new;

    assign msg_ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        end_pend_next  = end_pend_reg;
        marker_next    = marker_reg;
        in_len_next    = in_len_reg;
        last_blk_next  = last_blk_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        feed_byte      = msg.msg_byte;
        sched_ctrl.byte_shift = 1'b0;
        sched_ctrl.word_shift = 1'b0;
        round_ctrl.load_vars  = 1'b0;
        round_ctrl.step       = 1'b0;
        round_ctrl.fold       = 1'b0;
        round_ctrl.init_chain = 1'b0;

        if (rnd_reg < STAGE1_START)
        begin
            round_ctrl.stage = STG_CHOOSE;
        end
        else if (rnd_reg < STAGE2_START)
        begin
            round_ctrl.stage = STG_PARITY;
        end
        else if (rnd_reg < STAGE3_START)
        begin
            round_ctrl.stage = STG_MAJ;
        end
        else
        begin
            round_ctrl.stage = STG_PARITY2;
        end

        if (out_valid_reg && digest_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_valid)
                    begin
                        sched_ctrl.byte_shift = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (len_reg != LEN_MAX)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                    if (msg.end_of_message)
                    begin
                        end_pend_next = 1'b1;
                    end
                    if (msg.byte_valid && cnt_reg == BLOCK_LAST)
                    begin
                        round_ctrl.load_vars = 1'b1;
                        rnd_next   = '0;
                        state_next = S_ROUND;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                sched_ctrl.byte_shift = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (!marker_reg)
                begin
                    feed_byte   = PAD_MARKER;
                    marker_next = 1'b1;
                end
                else if (in_len_reg || cnt_reg == LEN_POS)
                begin
                    feed_byte   = len_byte;
                    in_len_next = 1'b1;
                    if (cnt_reg == BLOCK_LAST)
                    begin
                        last_blk_next = 1'b1;
                    end
                end
                else
                begin
                    feed_byte = '0;
                end
                if (cnt_reg == BLOCK_LAST)
                begin
                    round_ctrl.load_vars = 1'b1;
                    rnd_next   = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                round_ctrl.step       = 1'b1;
                sched_ctrl.word_shift = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == ROUND_LAST)
                begin
                    rnd_next   = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                round_ctrl.fold = 1'b1;
                if (last_blk_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (end_pend_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_data_next  = chain;
                    out_valid_next = 1'b1;
                    round_ctrl.init_chain = 1'b1;
                    len_next      = '0;
                    cnt_next      = '0;
                    end_pend_next = 1'b0;
                    marker_next   = 1'b0;
                    in_len_next   = 1'b0;
                    last_blk_next = 1'b0;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            end_pend_reg  <= 1'b0;
            marker_reg    <= 1'b0;
            in_len_reg    <= 1'b0;
            last_blk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            rnd_reg       <= rnd_next;
            end_pend_reg  <= end_pend_next;
            marker_reg    <= marker_next;
            in_len_reg    <= in_len_next;
            last_blk_reg  <= last_blk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_cell
        if (i == NUM_WORDS - 1)
        begin : g_tail
            sha1_sched_cell u_cell (
                .clk       (clk),
                .ctrl      (sched_ctrl),
                .next_word (tail_word),
                .word      (sched_q[i])
            );
        end
        else
        begin : g_body
            sha1_sched_cell u_cell (
                .clk       (clk),
                .ctrl      (sched_ctrl),
                .next_word (sched_q[i+1]),
                .word      (sched_q[i])
            );
        end
    end

    sha1_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (round_ctrl),
        .w     (sched_q[0]),
        .chain (chain)
    );

    assign digest_valid = out_valid_reg;
    assign digest       = out_data_reg;

endmodule

`default_nettype wire
